FILE: design/kdb_pkg.sv
// ----------------------------------------------------------------------------
// kdb_pkg
// Shared types and constants for the key debounce / long-short press block.
// ----------------------------------------------------------------------------
package kdb_pkg;

  localparam int TICK_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = CFG_IDX_W'(1);

  localparam logic [TICK_W-1:0] DEBOUNCE_RST   = TICK_W'(20);
  localparam logic [TICK_W-1:0] LONG_PRESS_RST = TICK_W'(1000);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DEB    = 2'd1;
  localparam logic [1:0] ST_STABLE = 2'd2;

  typedef logic [1:0] evt_code_t;

  localparam evt_code_t EV_PRESSED  = 2'd0;
  localparam evt_code_t EV_RELEASED = 2'd1;
  localparam evt_code_t EV_SHORT    = 2'd2;
  localparam evt_code_t EV_LONG     = 2'd3;

  typedef struct packed {
    evt_code_t code;
    logic      last;
  } evt_t;

  // Events produced by one scan: cnt is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] cnt;
    evt_t       ev0;
    evt_t       ev1;
  } evt_pair_t;

endpackage

FILE: design/key_debounce_long_short_press.sv
// ----------------------------------------------------------------------------
// key_debounce_long_short_press
// Key debounce with pressed / released / short-press / long-press events.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready    in_raw_level, in_now_tick
//   out_     output     out_valid / out_ready  out_event_code, out_last_of_run
//   cfg_     input      cfg_wr_en              cfg_index, cfg_wdata
//
// One scan is accepted per cycle, unless the input register holds a scan that
// cannot advance. A scan is held in the input register, is stepped through the
// state machine and lands in a 4-entry event queue, from which its events are
// handed out one at a time. Scans advance only while the queue has room for two
// events. Reset is synchronous, clears the machine and queue and loads the
// default times (20 and 1000 ticks).
// ----------------------------------------------------------------------------
module key_debounce_long_short_press (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_raw_level,
  input  logic [kdb_pkg::TICK_W-1:0]    in_now_tick,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_event_code,
  output logic                          out_last_of_run,
  input  logic                          cfg_wr_en,
  input  logic [kdb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kdb_pkg::TICK_W-1:0]    cfg_wdata
);

  logic                       in_vld_r;
  logic                       in_raw_r;
  logic [kdb_pkg::TICK_W-1:0] in_tick_r;
  logic [kdb_pkg::TICK_W-1:0] debounce_r;
  logic [kdb_pkg::TICK_W-1:0] long_press_r;
  logic                       room2;
  logic                       step;
  logic                       in_fire;
  kdb_pkg::evt_pair_t         evt;

  assign step     = in_vld_r && room2;
  assign in_ready = !in_vld_r || step;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_fire || (in_vld_r && !step);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_raw_r  <= in_raw_level;
      in_tick_r <= in_now_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= kdb_pkg::DEBOUNCE_RST;
      long_press_r <= kdb_pkg::LONG_PRESS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        kdb_pkg::CFG_DEBOUNCE:   debounce_r   <= cfg_wdata;
        kdb_pkg::CFG_LONG_PRESS: long_press_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  kdb_fsm u_fsm (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .raw_level       (in_raw_r),
    .now_tick        (in_tick_r),
    .debounce_time   (debounce_r),
    .long_press_time (long_press_r),
    .evt             (evt)
  );

  kdb_evt_fifo u_fifo (
    .clk             (clk),
    .rst_n           (rst_n),
    .wr_en           (step),
    .wr_evt          (evt),
    .room2           (room2),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_code  (out_event_code),
    .out_last_of_run (out_last_of_run)
  );

endmodule

FILE: design/kdb_fsm.sv
// ----------------------------------------------------------------------------
// kdb_fsm
// Debounce state machine: one scan per step, emits up to two events.
// ----------------------------------------------------------------------------
module kdb_fsm (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       raw_level,
  input  logic [kdb_pkg::TICK_W-1:0] now_tick,
  input  logic [kdb_pkg::TICK_W-1:0] debounce_time,
  input  logic [kdb_pkg::TICK_W-1:0] long_press_time,
  output kdb_pkg::evt_pair_t         evt
);

  logic [1:0]                 state_r, state_nxt;
  logic                       stable_r, stable_nxt;
  logic [kdb_pkg::TICK_W-1:0] chg_tick_r, chg_tick_nxt;
  logic [kdb_pkg::TICK_W-1:0] press_at_r, press_at_nxt;
  logic                       long_fired_r, long_fired_nxt;
  logic [kdb_pkg::TICK_W-1:0] deb_diff;
  logic [kdb_pkg::TICK_W-1:0] hold_diff;

  assign deb_diff  = now_tick - chg_tick_r;
  assign hold_diff = now_tick - press_at_r;

  always_comb begin
    state_nxt      = state_r;
    stable_nxt     = stable_r;
    chg_tick_nxt   = chg_tick_r;
    press_at_nxt   = press_at_r;
    long_fired_nxt = long_fired_r;
    evt            = '0;
    case (state_r)
      kdb_pkg::ST_IDLE: begin
        if (raw_level != stable_r) begin
          state_nxt    = kdb_pkg::ST_DEB;
          chg_tick_nxt = now_tick;
        end
      end
      kdb_pkg::ST_DEB: begin
        if (raw_level != stable_r) begin
          if (deb_diff >= debounce_time) begin
            stable_nxt = raw_level;
            state_nxt  = kdb_pkg::ST_STABLE;
            if (raw_level) begin
              press_at_nxt   = now_tick;
              long_fired_nxt = 1'b0;
              evt.cnt        = 2'd1;
              evt.ev0.code   = kdb_pkg::EV_PRESSED;
              evt.ev0.last   = 1'b1;
            end else if (!long_fired_r) begin
              evt.cnt      = 2'd2;
              evt.ev0.code = kdb_pkg::EV_RELEASED;
              evt.ev0.last = 1'b0;
              evt.ev1.code = kdb_pkg::EV_SHORT;
              evt.ev1.last = 1'b1;
            end else begin
              evt.cnt      = 2'd1;
              evt.ev0.code = kdb_pkg::EV_RELEASED;
              evt.ev0.last = 1'b1;
            end
          end
        end else begin
          // bounce back
          state_nxt = stable_r ? kdb_pkg::ST_STABLE : kdb_pkg::ST_IDLE;
        end
      end
      kdb_pkg::ST_STABLE: begin
        if (raw_level != stable_r) begin
          state_nxt    = kdb_pkg::ST_DEB;
          chg_tick_nxt = now_tick;
        end else if (raw_level && !long_fired_r && (hold_diff >= long_press_time)) begin
          long_fired_nxt = 1'b1;
          evt.cnt        = 2'd1;
          evt.ev0.code   = kdb_pkg::EV_LONG;
          evt.ev0.last   = 1'b1;
        end
      end
      default: begin
        state_nxt = kdb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kdb_pkg::ST_IDLE;
      stable_r     <= 1'b0;
      chg_tick_r   <= '0;
      press_at_r   <= '0;
      long_fired_r <= 1'b0;
    end else if (step) begin
      state_r      <= state_nxt;
      stable_r     <= stable_nxt;
      chg_tick_r   <= chg_tick_nxt;
      press_at_r   <= press_at_nxt;
      long_fired_r <= long_fired_nxt;
    end
  end

endmodule

FILE: design/kdb_evt_fifo.sv
// ----------------------------------------------------------------------------
// kdb_evt_fifo
// Result queue: takes up to two events a cycle, hands out one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module kdb_evt_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  kdb_pkg::evt_pair_t   wr_evt,
  output logic                 room2,
  output logic                 out_valid,
  input  logic                 out_ready,
  output kdb_pkg::evt_code_t   out_event_code,
  output logic                 out_last_of_run
);

  kdb_pkg::evt_t                mem_r [kdb_pkg::FIFO_DEPTH];
  logic [kdb_pkg::FIFO_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [kdb_pkg::FIFO_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [kdb_pkg::FIFO_AW:0]    cnt_r, cnt_nxt;
  logic [kdb_pkg::FIFO_AW:0]    n_push;
  logic                         pop;

  assign out_valid       = (cnt_r != '0);
  assign pop             = out_valid && out_ready;
  assign room2           = (cnt_r <= (kdb_pkg::FIFO_AW+1)'(kdb_pkg::FIFO_DEPTH - 2));
  assign out_event_code  = mem_r[rd_ptr_r].code;
  assign out_last_of_run = mem_r[rd_ptr_r].last;

  always_comb begin
    n_push     = wr_en ? (kdb_pkg::FIFO_AW+1)'(wr_evt.cnt) : '0;
    wr_ptr_nxt = wr_ptr_r + kdb_pkg::FIFO_AW'(n_push);
    rd_ptr_nxt = rd_ptr_r + kdb_pkg::FIFO_AW'(pop);
    cnt_nxt    = cnt_r + n_push - (kdb_pkg::FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_evt.cnt != 2'd0)) begin
      mem_r[wr_ptr_r] <= wr_evt.ev0;
    end
    if (wr_en && (wr_evt.cnt == 2'd2)) begin
      mem_r[wr_ptr_r + kdb_pkg::FIFO_AW'(1)] <= wr_evt.ev1;
    end
  end

endmodule

FILE: design/kdb_checker.sv
// ----------------------------------------------------------------------------
// kdb_checker
// Port-level checks for the key debounce block, bound to the top level.
// ----------------------------------------------------------------------------
module kdb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event_code,
  input logic       out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_event_code) && $stable(out_last_of_run))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_only_release_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_code != kdb_pkg::EV_RELEASED) |-> out_last_of_run)
    else $error("non-release event not last of its scan");

  a_short_follows_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_event_code == kdb_pkg::EV_RELEASED) && !out_last_of_run
      |=> out_valid && (out_event_code == kdb_pkg::EV_SHORT) && out_last_of_run)
    else $error("short-press item missing after release");

endmodule

bind key_debounce_long_short_press kdb_checker u_kdb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_event_code  (out_event_code),
  .out_last_of_run (out_last_of_run)
);

FILE: tb/tb_key_debounce_long_short_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_debounce_long_short_press
// Drives key scans (raw level plus free-running tick) into the debouncer and
// predicts pressed / released / short / long events with a cycle-free model
// of the state machine. Covers chatter, bounce back, tick wrap, zero and
// maximum register times, back-pressure and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_key_debounce_long_short_press;

  class key_event_model;
    logic [kdb_pkg::TICK_W-1:0] debounce_ticks = kdb_pkg::DEBOUNCE_RST;
    logic [kdb_pkg::TICK_W-1:0] long_ticks     = kdb_pkg::LONG_PRESS_RST;
    logic [1:0]                 state          = kdb_pkg::ST_IDLE;
    logic                       level          = 1'b0;
    logic [kdb_pkg::TICK_W-1:0] change_tick    = '0;
    logic [kdb_pkg::TICK_W-1:0] press_at       = '0;
    logic                       long_done      = 1'b0;
    kdb_pkg::evt_t              due_events[$];
    int                         errors         = 0;
    int                         seen[4];

    function void set_reg(logic [kdb_pkg::CFG_IDX_W-1:0] idx,
                          logic [kdb_pkg::TICK_W-1:0] val);
      case (idx)
        kdb_pkg::CFG_DEBOUNCE:   debounce_ticks = val;
        kdb_pkg::CFG_LONG_PRESS: long_ticks = val;
        default: ;
      endcase
    endfunction

    function void emit_event(kdb_pkg::evt_code_t code, logic last);
      kdb_pkg::evt_t e;
      e.code = code;
      e.last = last;
      due_events.push_back(e);
    endfunction

    function void note_scan(logic raw, logic [kdb_pkg::TICK_W-1:0] now);
      logic [kdb_pkg::TICK_W-1:0] since_change;
      logic [kdb_pkg::TICK_W-1:0] since_press;
      since_change = now - change_tick;
      since_press  = now - press_at;
      case (state)
        kdb_pkg::ST_IDLE: begin
          if (raw != level) begin
            state = kdb_pkg::ST_DEB;
            change_tick = now;
          end
        end
        kdb_pkg::ST_DEB: begin
          if (raw == level) begin
            state = level ? kdb_pkg::ST_STABLE : kdb_pkg::ST_IDLE;
          end else if (since_change >= debounce_ticks) begin
            level = raw;
            state = kdb_pkg::ST_STABLE;
            if (raw) begin
              press_at = now;
              long_done = 1'b0;
              emit_event(kdb_pkg::EV_PRESSED, 1'b1);
            end else if (!long_done) begin
              emit_event(kdb_pkg::EV_RELEASED, 1'b0);
              emit_event(kdb_pkg::EV_SHORT, 1'b1);
            end else begin
              emit_event(kdb_pkg::EV_RELEASED, 1'b1);
            end
          end
        end
        kdb_pkg::ST_STABLE: begin
          if (raw != level) begin
            state = kdb_pkg::ST_DEB;
            change_tick = now;
          end else if (raw && !long_done && since_press >= long_ticks) begin
            long_done = 1'b1;
            emit_event(kdb_pkg::EV_LONG, 1'b1);
          end
        end
        default: state = kdb_pkg::ST_IDLE;
      endcase
    endfunction

    function void check_event(kdb_pkg::evt_code_t code, logic last);
      kdb_pkg::evt_t want;
      if (due_events.size() == 0) begin
        $error("unexpected event: event_code %0d last_of_run %0d", code, last);
        errors++;
        return;
      end
      want = due_events.pop_front();
      seen[want.code]++;
      if (code !== want.code) begin
        $error("event_code: expected %0d, actual %0d", want.code, code);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return due_events.size();
    endfunction
  endclass

  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          in_valid        = 1'b0;
  logic                          in_ready;
  logic                          in_raw_level    = 1'b0;
  logic [kdb_pkg::TICK_W-1:0]    in_now_tick     = '0;
  logic                          out_valid;
  logic                          out_ready       = 1'b0;
  logic [1:0]                    out_event_code;
  logic                          out_last_of_run;
  logic                          cfg_wr_en       = 1'b0;
  logic [kdb_pkg::CFG_IDX_W-1:0] cfg_index       = '0;
  logic [kdb_pkg::TICK_W-1:0]    cfg_wdata       = '0;

  key_event_model events_due = new();

  int                         gap_pct   = 0;
  int                         stall_pct = 0;
  bit                         hold_req  = 1'b0;
  int                         hold_left = 0;
  int                         n_scans   = 0;
  int                         n_settings = 0;
  int                         dspan     = 20;
  int                         lspan     = 1000;
  logic [kdb_pkg::TICK_W-1:0] tick      = '0;

  key_debounce_long_short_press dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_raw_level   (in_raw_level),
    .in_now_tick    (in_now_tick),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_code (out_event_code),
    .out_last_of_run(out_last_of_run),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #1 clk = ~clk;

  // event sink: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      events_due.check_event(out_event_code, out_last_of_run);
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [kdb_pkg::TICK_W-1:0] adv(input logic [kdb_pkg::TICK_W-1:0] d);
    tick = tick + d;
    return tick;
  endfunction

  task automatic send_scan(input logic raw, input logic [kdb_pkg::TICK_W-1:0] now);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_raw_level <= raw;
    in_now_tick  <= now;
    do @(posedge clk); while (!in_ready);
    events_due.note_scan(raw, now);
    n_scans++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (events_due.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kdb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kdb_pkg::TICK_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    events_due.set_reg(idx, val);
  endtask

  task automatic set_times(input logic [kdb_pkg::TICK_W-1:0] deb,
                           input logic [kdb_pkg::TICK_W-1:0] lp);
    drain();
    write_reg(kdb_pkg::CFG_DEBOUNCE, deb);
    write_reg(kdb_pkg::CFG_LONG_PRESS, lp);
    cfg_wr_en <= 1'b0;
    dspan = (deb > 2000) ? 2000 : int'(deb);
    lspan = (lp > 50000) ? 50000 : int'(lp);
    n_settings++;
  endtask

  // chatter, then hold the new level long enough to pass debounce times up to 2000 ticks
  task automatic settle(input logic lvl);
    repeat ($urandom_range(0, 3)) begin
      send_scan(lvl, adv($urandom_range(0, dspan / 4)));
      send_scan(!lvl, adv($urandom_range(0, dspan / 4)));
    end
    repeat ($urandom_range(1, 4)) send_scan(lvl, adv($urandom_range(0, dspan / 2 + 1)));
    send_scan(lvl, adv(dspan));
  endtask

  task automatic key_stroke();
    settle(1'b1);
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(9) == 0)
        send_scan(1'b0, adv($urandom_range(0, dspan / 2)));
      else
        send_scan(1'b1, adv($urandom_range(0, lspan / 3 + 1)));
    end
    settle(1'b0);
    repeat ($urandom_range(0, 4)) send_scan(1'b0, adv($urandom_range(0, dspan + 3)));
  endtask

  task automatic run_phase(input logic [kdb_pkg::TICK_W-1:0] deb,
                           input logic [kdb_pkg::TICK_W-1:0] lp,
                           input int count, input int gap, input int stall,
                           input bit hold, input bit pause);
    int first;
    int r;
    set_times(deb, lp);
    gap_pct   = gap;
    stall_pct = stall;
    tick      = $urandom;
    first     = n_scans;
    if (hold) hold_req = 1'b1;
    while (n_scans - first < count) begin
      if (pause && n_scans - first >= count / 2) begin
        pause = 1'b0;
        drain();
      end
      r = $urandom_range(99);
      if (r < 75) begin
        key_stroke();
      end else if (r < 90) begin
        repeat ($urandom_range(1, 6))
          send_scan(1'($urandom_range(0, 1)), adv($urandom_range(0, dspan + 5)));
      end else begin
        send_scan(1'($urandom_range(0, 1)), adv($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    gap_pct   = 31;
    stall_pct = 54;

    // reset times: bounce back to idle, press across tick wrap, bounce back to
    // stable, long press, release after long, short press
    send_scan(1'b0, 32'h0000_0000);
    send_scan(1'b1, 32'hFFFF_FFF0);
    send_scan(1'b0, 32'hFFFF_FFF5);
    send_scan(1'b1, 32'hFFFF_FFFA);
    send_scan(1'b1, 32'd5);
    send_scan(1'b1, 32'd14);
    send_scan(1'b1, 32'd500);
    send_scan(1'b0, 32'd510);
    send_scan(1'b1, 32'd520);
    send_scan(1'b1, 32'd1014);
    send_scan(1'b1, 32'd1100);
    send_scan(1'b0, 32'd1200);
    send_scan(1'b0, 32'd1220);
    send_scan(1'b1, 32'd1300);
    send_scan(1'b1, 32'd1320);
    send_scan(1'b0, 32'd1400);
    send_scan(1'b0, 32'd1420);

    // zero times
    set_times('0, '0);
    send_scan(1'b1, 32'd0);
    send_scan(1'b1, 32'd0);
    send_scan(1'b1, 32'd0);
    send_scan(1'b0, 32'hFFFF_FFFF);
    send_scan(1'b0, 32'hFFFF_FFFF);

    // maximum times: only a full-wrap difference qualifies
    set_times('1, '1);
    send_scan(1'b1, 32'd7);
    send_scan(1'b1, 32'd5);
    send_scan(1'b1, 32'd6);
    send_scan(1'b1, 32'd5);
    send_scan(1'b0, 32'd100);
    send_scan(1'b0, 32'd99);

    run_phase(32'd3,  32'd40,    330, 31, 54, 1'b0, 1'b0);
    run_phase(32'd0,  32'd0,     150, 31, 54, 1'b0, 1'b0);
    run_phase(32'd1,  32'd7,     170, 31, 54, 1'b0, 1'b0);
    run_phase(32'd20, 32'd1000,  330, 54, 31, 1'b0, 1'b1);
    run_phase('1,     '1,         60, 54, 31, 1'b0, 1'b0);
    run_phase(32'd10, 32'hFFFF_FFFF, 260, 54, 31, 1'b0, 1'b0);
    run_phase(32'd5,  32'd200,   330, 0,  0,  1'b1, 1'b0);
    run_phase(32'd0,  32'd12,    320, 0,  0,  1'b0, 1'b0);

    drain();
    repeat (10) @(posedge clk);

    $display("covered %0d scans over %0d register settings, with chatter, wrap and stalls",
             n_scans, n_settings);
    $display("events checked: %0d pressed, %0d released, %0d short, %0d long",
             events_due.seen[kdb_pkg::EV_PRESSED], events_due.seen[kdb_pkg::EV_RELEASED],
             events_due.seen[kdb_pkg::EV_SHORT], events_due.seen[kdb_pkg::EV_LONG]);
    if (events_due.errors == 0 && events_due.pending() == 0) begin
      $display("tb_key_debounce_long_short_press OK");
    end else begin
      $display("tb_key_debounce_long_short_press NOT OK");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("tb_key_debounce_long_short_press NOT OK");
    $finish;
  end

endmodule

FILE: key_debounce_long_short_press.f
design/kdb_pkg.sv
design/kdb_fsm.sv
design/kdb_evt_fifo.sv
design/key_debounce_long_short_press.sv
design/kdb_checker.sv
tb/tb_key_debounce_long_short_press.sv
